// ----- sv/bsr_pkg.sv -----
`timescale 1ns / 1ps
// bsr_pkg: shared types, constants and the popcount function of the bit store
// used by bsr_ctrl, bsr_dp and bitset_with_zero_rank_top; depends on nothing

package bsr_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_WORDS_DEF = 128;
    localparam int MAX_WORD_BITS = 64;
    localparam int INDEX_W = 12;
    localparam int LIMIT_W = 13;
    localparam int COUNT_W = 13;
    localparam int POP_W = 7;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_GAPS  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_READ,
        ST_MODIFY,
        ST_GAP_READ,
        ST_GAP_ACC,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic fix_step;
        logic read_word;
        logic modify_word;
        logic gap_read;
        logic gap_acc;
        logic clear_word;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_err;
        logic lim_zero;
        logic gap_last;
        logic clear_last;
    } dp_status_t;

    function automatic logic [POP_W-1:0] popcount64(input logic [MAX_WORD_BITS-1:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++)
        begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

// ----- sv/bsr_ctrl.sv -----
`timescale 1ns / 1ps
// bsr_ctrl: sequencer of the bit store, handshakes and datapath commands
// depends on bsr_pkg

module bsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            command,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bsr_pkg::dp_cmd_t      dp_cmd,
    input  bsr_pkg::dp_status_t   dp_status
);

    bsr_pkg::state_t state_reg;
    bsr_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != bsr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsr_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsr_pkg::ST_INIT:
            begin
                if (dp_status.clear_last)
                    state_next = bsr_pkg::ST_IDLE;
            end
            bsr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (bsr_pkg::cmd_t'(command))
                        bsr_pkg::CMD_SET,
                        bsr_pkg::CMD_CHECK: state_next = bsr_pkg::ST_DIV;
                        bsr_pkg::CMD_GAPS:  state_next = bsr_pkg::ST_GAP_READ;
                        bsr_pkg::CMD_CLEAR: state_next = bsr_pkg::ST_CLEAR;
                    endcase
                end
            end
            bsr_pkg::ST_DIV:
            begin
                state_next = dp_status.idx_err ? bsr_pkg::ST_DONE : bsr_pkg::ST_FIX;
            end
            bsr_pkg::ST_FIX:    state_next = bsr_pkg::ST_READ;
            bsr_pkg::ST_READ:   state_next = bsr_pkg::ST_MODIFY;
            bsr_pkg::ST_MODIFY: state_next = bsr_pkg::ST_DONE;
            bsr_pkg::ST_GAP_READ:
            begin
                state_next = dp_status.lim_zero ? bsr_pkg::ST_DONE : bsr_pkg::ST_GAP_ACC;
            end
            bsr_pkg::ST_GAP_ACC:
            begin
                state_next = dp_status.gap_last ? bsr_pkg::ST_DONE : bsr_pkg::ST_GAP_READ;
            end
            bsr_pkg::ST_CLEAR:
            begin
                if (dp_status.clear_last)
                    state_next = bsr_pkg::ST_DONE;
            end
            bsr_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = bsr_pkg::ST_IDLE;
            end
            default: state_next = bsr_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        dp_cmd         = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            bsr_pkg::ST_INIT:     dp_cmd.clear_word  = 1'b1;
            bsr_pkg::ST_IDLE:     dp_cmd.load_item   = in_valid;
            bsr_pkg::ST_DIV:      dp_cmd.div_step    = 1'b1;
            bsr_pkg::ST_FIX:      dp_cmd.fix_step    = 1'b1;
            bsr_pkg::ST_READ:     dp_cmd.read_word   = 1'b1;
            bsr_pkg::ST_MODIFY:   dp_cmd.modify_word = 1'b1;
            bsr_pkg::ST_GAP_READ: dp_cmd.gap_read    = 1'b1;
            bsr_pkg::ST_GAP_ACC:  dp_cmd.gap_acc     = 1'b1;
            bsr_pkg::ST_CLEAR:    dp_cmd.clear_word  = 1'b1;
            bsr_pkg::ST_DONE:
            begin
                dp_cmd.load_out = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: dp_cmd = '0;
        endcase
    end

endmodule

// ----- sv/bsr_dp.sv -----
`timescale 1ns / 1ps
// bsr_dp: bit store memory, index split, gap accumulator and result register
// depends on bsr_pkg; driven by bsr_ctrl

module bsr_dp #(
    parameter int WORD_BITS = bsr_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = bsr_pkg::NUM_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsr_pkg::dp_cmd_t              dp_cmd,
    output bsr_pkg::dp_status_t           dp_status,
    input  logic [1:0]                    command,
    input  logic [bsr_pkg::INDEX_W-1:0]   bit_index,
    input  logic [bsr_pkg::LIMIT_W-1:0]   limit,
    output logic                          is_marked,
    output logic [bsr_pkg::COUNT_W-1:0]   gap_count,
    output logic                          range_error
);

    localparam int CAP   = NUM_WORDS * WORD_BITS;
    localparam int CW    = $clog2(CAP + 1);
    localparam int LW    = (CW > bsr_pkg::LIMIT_W) ? CW : bsr_pkg::LIMIT_W;
    localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BPW   = $clog2(WORD_BITS);
    localparam int IW    = bsr_pkg::INDEX_W;
    localparam int SHIFT = IW + 7;
    localparam int RECIP = (1 << SHIFT) / WORD_BITS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = IW + RW;

    logic [WORD_BITS-1:0]          mem_q [NUM_WORDS];
    logic [WORD_BITS-1:0]          rdata_reg;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [WORD_BITS-1:0]          mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;

    bsr_pkg::cmd_t                 cmd_reg;
    logic [IW-1:0]                 idx_reg;
    logic [CW-1:0]                 lim_sat_reg;
    logic                          idx_err_reg;
    logic                          err_reg;
    logic [IW-1:0]                 q0_reg;
    logic [AW-1:0]                 word_addr_reg;
    logic [BPW-1:0]                bit_pos_reg;
    logic                          marked_reg;
    logic [AW-1:0]                 addr_reg;
    logic [CW-1:0]                 base_reg;
    logic [bsr_pkg::COUNT_W-1:0]   acc_reg;
    logic                          is_marked_reg;
    logic [bsr_pkg::COUNT_W-1:0]   gap_count_reg;
    logic                          range_error_reg;

    logic [LW:0]                   limit_ext;
    logic [LW:0]                   index_ext;
    logic                          lim_err;
    logic                          idx_err;
    logic [PW-1:0]                 prod;
    logic [IW-1:0]                 q_times_w;
    logic [IW-1:0]                 rem_raw;
    logic [CW-1:0]                 remaining;
    logic [CW:0]                   next_base;
    logic [WORD_BITS-1:0]          gap_mask;
    logic [bsr_pkg::POP_W-1:0]     pop;

    assign limit_ext = (LW + 1)'(limit);
    assign index_ext = (LW + 1)'(bit_index);
    assign lim_err   = limit_ext > (LW + 1)'(CAP);
    assign idx_err   = index_ext >= (LW + 1)'(CAP);

    assign prod      = PW'(idx_reg) * PW'(RECIP);
    assign q_times_w = IW'(q0_reg * IW'(WORD_BITS));
    assign rem_raw   = idx_reg - q_times_w;

    assign remaining = lim_sat_reg - base_reg;
    assign next_base = {1'b0, base_reg} + (CW + 1)'(WORD_BITS);

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            gap_mask[j] = (remaining > CW'(j));
        end
    end

    assign pop = bsr_pkg::popcount64(bsr_pkg::MAX_WORD_BITS'(~rdata_reg & gap_mask));

    assign dp_status.idx_err    = idx_err_reg;
    assign dp_status.lim_zero   = (lim_sat_reg == '0);
    assign dp_status.gap_last   = (next_base >= {1'b0, lim_sat_reg});
    assign dp_status.clear_last = (addr_reg == AW'(NUM_WORDS - 1));

    // one write and one read port
    assign mem_we    = dp_cmd.clear_word || (dp_cmd.modify_word && cmd_reg == bsr_pkg::CMD_SET);
    assign mem_waddr = dp_cmd.clear_word ? addr_reg : word_addr_reg;
    assign mem_wdata = dp_cmd.clear_word ? '0
                     : (rdata_reg | (WORD_BITS'(1) << bit_pos_reg));
    assign mem_re    = dp_cmd.read_word || dp_cmd.gap_read;
    assign mem_raddr = dp_cmd.gap_read ? addr_reg : word_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_q[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem_q[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (dp_cmd.load_item)
        begin
            addr_reg <= '0;
        end
        else if (dp_cmd.clear_word || dp_cmd.gap_acc)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_item)
        begin
            cmd_reg     <= bsr_pkg::cmd_t'(command);
            idx_reg     <= bit_index;
            lim_sat_reg <= lim_err ? CW'(CAP) : CW'(limit);
            idx_err_reg <= idx_err;
            base_reg    <= '0;
            acc_reg     <= '0;
            marked_reg  <= 1'b0;
            unique case (bsr_pkg::cmd_t'(command))
                bsr_pkg::CMD_SET,
                bsr_pkg::CMD_CHECK: err_reg <= idx_err;
                bsr_pkg::CMD_GAPS:  err_reg <= lim_err;
                bsr_pkg::CMD_CLEAR: err_reg <= 1'b0;
            endcase
        end
        if (dp_cmd.div_step)
        begin
            q0_reg <= IW'(prod >> SHIFT);
        end
        if (dp_cmd.fix_step)
        begin
            if (rem_raw >= IW'(WORD_BITS))
            begin
                word_addr_reg <= AW'(q0_reg + IW'(1));
                bit_pos_reg   <= BPW'(rem_raw - IW'(WORD_BITS));
            end
            else
            begin
                word_addr_reg <= AW'(q0_reg);
                bit_pos_reg   <= BPW'(rem_raw);
            end
        end
        if (dp_cmd.modify_word && cmd_reg == bsr_pkg::CMD_CHECK)
        begin
            marked_reg <= rdata_reg[bit_pos_reg];
        end
        if (dp_cmd.gap_acc)
        begin
            acc_reg  <= acc_reg + bsr_pkg::COUNT_W'(pop);
            base_reg <= CW'(next_base);
        end
        if (dp_cmd.load_out)
        begin
            is_marked_reg   <= marked_reg;
            gap_count_reg   <= acc_reg;
            range_error_reg <= err_reg;
        end
    end

    assign is_marked   = is_marked_reg;
    assign gap_count   = gap_count_reg;
    assign range_error = range_error_reg;

endmodule

// ----- sv/bitset_with_zero_rank_top.sv -----
`timescale 1ns / 1ps
// bitset_with_zero_rank_top: bit store with set, check, zero count and clear
// depends on bsr_pkg, bsr_ctrl and bsr_dp

// The store holds NUM_WORDS words of WORD_BITS bits in a memory with one write
// port and one registered read port, and one item is worked at a time. After
// reset the block sweeps the memory to zero, one word a cycle, with in_stall
// high. Set and check run the index split, a word read and then a write for
// set or a bit test for check, and skip to the result register after the
// split's first step when the index is beyond capacity. Gaps reads and counts
// words in turn, ceil(limit / WORD_BITS) of them with the limit saturated at
// capacity, or none when the limit is zero. Clear zeroes all NUM_WORDS words
// in turn. Each item waits for the result register while the previous result
// still waits there. A new item is taken the cycle after a result enters the
// output register, even if that result has not been taken yet.

module bitset_with_zero_rank_top #(
    parameter int WORD_BITS = bsr_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = bsr_pkg::NUM_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [bsr_pkg::INDEX_W-1:0]   bit_index,
    input  logic [bsr_pkg::LIMIT_W-1:0]   limit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_marked,
    output logic [bsr_pkg::COUNT_W-1:0]   gap_count,
    output logic                          range_error
);

    bsr_pkg::dp_cmd_t    dp_cmd;
    bsr_pkg::dp_status_t dp_status;

    bsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    bsr_dp #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .command     (command),
        .bit_index   (bit_index),
        .limit       (limit),
        .is_marked   (is_marked),
        .gap_count   (gap_count),
        .range_error (range_error)
    );

endmodule
